/* design/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque: transaction structs,
// operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // default store depth
  localparam int DEPTH_DEF = 64;

  // operation codes
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_REAR   = 3'd3;
  localparam logic [2:0] KIND_DUMP       = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // request transaction
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } cdq_req_t;

  // response transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] word;
    logic               last;
  } cdq_rsp_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_DUMP_OUT
  } cdq_state_t;

endpackage

/* design/cdq_step.sv */
// ----------------------------------------------------------------------------
// cdq_step
// Shared index stepper: moves a store index one place up or down, wrapping
// modulo the store depth.
// ----------------------------------------------------------------------------
module cdq_step #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic [$clog2(DEPTH)-1:0] idx,
  input  logic                     up,
  output logic [$clog2(DEPTH)-1:0] result
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  // wrap at either end
  always_comb begin
    if (up) begin
      result = (idx == LAST_IDX) ? '0 : idx + IW'(1);
    end else begin
      result = (idx == '0) ? LAST_IDX : idx - IW'(1);
    end
  end

endmodule

/* design/circular_deque_unit.sv */
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed 32-bit words in a circular store, driven by a
// small sequencer around one shared index stepper.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | cdq_req_t  (kind, value)
//  rsp     | out       | rsp_valid/rsp_ready  | cdq_rsp_t  (status, word, last)
//
//  Push, pop or refusal: each transaction steps through accept, execute and
//  load the output register; ready is low from acceptance until the sequencer
//  is idle again, and the result then waits in the output register.
//  Dump of N entries: the single read port of the store gives one entry per
//  cycle while the output is taken each cycle.
//  Unused kind codes give no result.
//  Reset (rst, synchronous) empties the deque; store contents are not cleared.
//  A stalled output holds the sequencer in its emit or dump state.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cdq_pkg::cdq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cdq_pkg::cdq_rsp_t rsp
);

  import cdq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);

  cdq_state_t state, state_next;

  logic [2:0]         kind;
  logic signed [31:0] value;
  logic [IW-1:0]      head, tail, ptr;
  logic [OW-1:0]      occ, cnt;
  logic [1:0]         pend_status;
  logic               pend_from_mem;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;

  logic          full, empty, out_free, dump_last;
  logic [IW-1:0] step_idx, step_out;
  logic          step_up;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic          rsp_load;
  cdq_rsp_t      rsp_next;

  assign full      = (occ == OW'(DEPTH));
  assign empty     = (occ == '0);
  assign out_free  = !rsp_valid || rsp_ready;
  assign dump_last = ((cnt + OW'(1)) == occ);

  // shared index stepper
  cdq_step #(.DEPTH(DEPTH)) u_step (
    .idx    (step_idx),
    .up     (step_up),
    .result (step_out)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (kind)
          KIND_PUSH_FRONT, KIND_PUSH_REAR,
          KIND_POP_FRONT, KIND_POP_REAR: state_next = S_EMIT;
          KIND_DUMP: state_next = empty ? S_EMIT : S_DUMP_OUT;
          default: state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      S_DUMP_OUT: begin
        if (out_free && dump_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: stepper operand, store port, result load
  always_comb begin
    req_ready = 1'b0;
    step_idx  = head;
    step_up   = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_re    = 1'b0;
    mem_raddr = head;
    rsp_load  = 1'b0;
    rsp_next  = '{status: pend_status, word: (pend_from_mem ? rdata : '0), last: 1'b1};
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_EXEC: begin
        case (kind)
          KIND_PUSH_FRONT: begin
            step_idx  = head;
            step_up   = 1'b0;
            mem_we    = !full;
            mem_waddr = empty ? '0 : step_out;
          end
          KIND_PUSH_REAR: begin
            step_idx  = tail;
            step_up   = 1'b1;
            mem_we    = !full;
            mem_waddr = empty ? '0 : step_out;
          end
          KIND_POP_FRONT: begin
            step_idx  = head;
            step_up   = 1'b1;
            mem_re    = !empty;
            mem_raddr = head;
          end
          KIND_POP_REAR: begin
            step_idx  = tail;
            step_up   = 1'b0;
            mem_re    = !empty;
            mem_raddr = tail;
          end
          KIND_DUMP: begin
            mem_re    = !empty;
            mem_raddr = head;
          end
          default: begin
            mem_re = 1'b0;
          end
        endcase
      end
      S_EMIT: begin
        rsp_load = out_free;
      end
      S_DUMP_OUT: begin
        step_idx  = ptr;
        step_up   = 1'b1;
        rsp_load  = out_free;
        mem_re    = out_free && !dump_last;
        mem_raddr = step_out;
        rsp_next  = '{status: ST_DONE, word: rdata, last: dump_last};
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // deque control: indices, occupancy, dump walk, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      ptr       <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_EXEC) begin
        case (kind)
          KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
            if (!full) begin
              occ <= occ + OW'(1);
              if (empty) begin
                head <= '0;
                tail <= '0;
              end else if (kind == KIND_PUSH_FRONT) begin
                head <= step_out;
              end else begin
                tail <= step_out;
              end
            end
          end
          KIND_POP_FRONT, KIND_POP_REAR: begin
            if (!empty) begin
              occ <= occ - OW'(1);
              if (occ == OW'(1)) begin
                head <= '0;
                tail <= '0;
              end else if (kind == KIND_POP_FRONT) begin
                head <= step_out;
              end else begin
                tail <= step_out;
              end
            end
          end
          KIND_DUMP: begin
            ptr <= head;
            cnt <= '0;
          end
          default: begin
            cnt <= cnt;
          end
        endcase
      end
      if (state == S_DUMP_OUT && out_free && !dump_last) begin
        ptr <= step_out;
        cnt <= cnt + OW'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload: latched request, pending status, output register
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      kind  <= req.kind;
      value <= req.value;
    end
    if (state == S_EXEC) begin
      pend_from_mem <= 1'b0;
      case (kind)
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          pend_status <= full ? ST_FULL : ST_DONE;
        end
        KIND_POP_FRONT, KIND_POP_REAR: begin
          pend_status   <= empty ? ST_EMPTY : ST_DONE;
          pend_from_mem <= !empty;
        end
        default: begin
          pend_status <= ST_EMPTY;
        end
      endcase
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // circular store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= value;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // occupancy never passes the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(DEPTH))
    else $error("occupancy above depth");

  // an empty deque has both indices at zero
  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> (head == '0 && tail == '0))
    else $error("indices not cleared on empty deque");

  // an accepted request is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_EXEC))
    else $error("accepted request not executed");

  // the dump walk stays inside the occupied entries
  a_dump_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP_OUT) |-> (cnt < occ))
    else $error("dump walk beyond occupancy");

endmodule
